>>> sv/smf_pkg.sv
`default_nettype none
package smf_pkg;

  localparam int unsigned CFG_W      = 5;
  localparam int unsigned WS_RESET   = 5;
  localparam int unsigned HIST_DEPTH = 64;
  localparam int unsigned HIST_AW    = 6;
  localparam int unsigned RESULT_CAP = 16;
  localparam int unsigned CAP_W      = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_OUT
  } seq_state_e;

endpackage
`default_nettype wire

>>> sv/sliding_median_filter_reflect.sv
`default_nettype none
// Sliding-window median over one range scan with mirrored borders. Each
// accepted sample is stored, then every output position that has become
// complete, up to RESULT_CAP per input, is worked out in turn: the
// window_size samples are read from the history memory one per cycle and
// dropped into a sorted register row, and the element of rank window_size/2
// is offered. Each result passes through check, reads, drain and output
// transfer; the history memory's single read port paces the reads. The input
// is stalled throughout.
module sliding_median_filter_reflect #(
  parameter int unsigned MAX_WINDOW  = 31,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_SCAN    = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [smf_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]   range_sample_i,
  input  wire logic                     scan_end_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [SAMPLE_BITS-1:0]        median_range_o,
  output logic                          last_of_run_o
);
  import smf_pkg::*;

  localparam int unsigned PW = $clog2(MAX_SCAN) + 1;
  localparam int unsigned JW = PW + 2;
  localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned NW = $clog2(MAX_WINDOW + 1);

  seq_state_e state_q, state_d;
  logic [CFG_W-1:0] ws_cfg_q;
  logic [PW-1:0] rcv_q, rcv_d, og_q, og_d;
  logic [CAP_W-1:0] cnt_q, cnt_d;
  logic end_q, end_d;
  logic [NW-1:0] k_q, k_d, ins_q, ins_d;
  logic rd_v_q, rd_v_d;
  logic [SAMPLE_BITS-1:0] srt_q [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] srt_d [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] mem_q [HIST_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic rd_en;
  logic [HIST_AW-1:0] rd_addr;

  logic [NW-1:0] ws_eff;
  logic [NW-1:0] off;
  logic cond;
  logic signed [JW-1:0] jn, j1, j2, rs;
  logic [MAX_WINDOW-1:0] le;
  logic accept;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    if (ws_cfg_q == '0) begin
      ws_eff = NW'(1);
    end else if (32'(ws_cfg_q) > MAX_WINDOW) begin
      ws_eff = NW'(MAX_WINDOW);
    end else begin
      ws_eff = NW'(ws_cfg_q);
    end
    off = ws_eff >> 1;
  end

  always_comb begin
    if (end_q) begin
      cond = (og_q <= rcv_q) && (cnt_q < CAP_W'(RESULT_CAP));
    end else begin
      cond = ((PW+1)'(og_q) + (PW+1)'(off) <= (PW+1)'(rcv_q))
             && (cnt_q < CAP_W'(RESULT_CAP));
    end
  end

  // mirrored window index for read k
  always_comb begin
    rs = JW'(rcv_q);
    jn = JW'(og_q) - JW'(off) + JW'(k_q);
    j1 = (jn < 0) ? -jn : jn;
    j2 = (j1 > rs) ? (rs + rs - j1) : j1;
    if (j2 < 0) begin
      j2 = '0;
    end else if (j2 > rs) begin
      j2 = rs;
    end
    rd_addr = j2[HIST_AW-1:0];
  end

  // sorted insertion of the returned sample
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      le[i] = (NW'(i) < ins_q) && (srt_q[i] <= rd_q);
    end
    if (le[0]) begin
      srt_d[0] = srt_q[0];
    end else begin
      srt_d[0] = rd_q;
    end
    for (int i = 1; i < MAX_WINDOW; i++) begin
      if (le[i]) begin
        srt_d[i] = srt_q[i];
      end else if (le[i-1]) begin
        srt_d[i] = rd_q;
      end else begin
        srt_d[i] = srt_q[i-1];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    rcv_d   = rcv_q;
    og_d    = og_q;
    cnt_d   = cnt_q;
    end_d   = end_q;
    k_d     = k_q;
    ins_d   = ins_q;
    rd_v_d  = 1'b0;
    rd_en   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          end_d   = scan_end_i || (32'(rcv_q) >= MAX_SCAN - 1);
          cnt_d   = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        k_d   = '0;
        ins_d = '0;
        if (cond) begin
          state_d = ST_LOAD;
        end else begin
          if (end_q) begin
            rcv_d = '0;
            og_d  = '0;
          end else begin
            rcv_d = rcv_q + PW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (rd_v_q) begin
          ins_d = ins_q + NW'(1);
        end
        if (k_q < ws_eff) begin
          rd_en  = 1'b1;
          rd_v_d = 1'b1;
          k_d    = k_q + NW'(1);
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          og_d    = og_q + PW'(1);
          cnt_d   = cnt_q + CAP_W'(1);
          state_d = ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ws_cfg_q <= CFG_W'(WS_RESET);
      rcv_q    <= '0;
      og_q     <= '0;
      cnt_q    <= '0;
      end_q    <= 1'b0;
      k_q      <= '0;
      ins_q    <= '0;
      rd_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        ws_cfg_q <= cfg_wdata_i;
      end
      rcv_q  <= rcv_d;
      og_q   <= og_d;
      cnt_q  <= cnt_d;
      end_q  <= end_d;
      k_q    <= k_d;
      ins_q  <= ins_d;
      rd_v_q <= rd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD && rd_v_q) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        srt_q[i] <= srt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[rcv_q[HIST_AW-1:0]] <= range_sample_i;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = (state_q == ST_OUT);
  assign median_range_o = srt_q[off[IW-1:0]];
  assign last_of_run_o  = end_q && (og_q == rcv_q);

endmodule
`default_nettype wire

>>> sv/smf_checker.sv
`default_nettype none
module smf_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [SAMPLE_BITS-1:0] median_range_o,
  input wire logic                   last_of_run_o
);

  // results only while the input side is held off
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("result offered while idle");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("not busy after input transfer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(median_range_o) && $stable(last_of_run_o)))
    else $error("stalled result changed");

endmodule

bind sliding_median_filter_reflect smf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_smf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .median_range_o(median_range_o),
  .last_of_run_o (last_of_run_o)
);
`default_nettype wire
